// ----- src/timed_entry_table_with_eviction_unit_macros.svh -----
// Assertion macros used by the checker file of the timed entry table.
`ifndef TIMED_ENTRY_TABLE_WITH_EVICTION_UNIT_MACROS_SVH
`define TIMED_ENTRY_TABLE_WITH_EVICTION_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define TET_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define TET_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- src/tet_pkg.sv -----
// Package with the shared constants and types of the entry table.
`default_nettype none
package tet_pkg;
   localparam int CAPACITY  = 64;
   localparam int KIND_BITS = 8;
   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam logic [1:0] OP_INSERT       = 2'd0;
   localparam logic [1:0] OP_SCAN         = 2'd1;
   localparam logic [1:0] OP_REMOVE_OWNER = 2'd2;
   localparam logic [1:0] OP_REMOVE_KIND  = 2'd3;
   localparam logic CSR_ENTRY_LIMIT = 1'b0;
   localparam logic CSR_SCAN_ENABLE = 1'b1;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [31:0]          owner;
      logic [31:0]          start;
      logic [30:0]          span;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_SEL, ST_EVICT, ST_WRITE, ST_SCAN, ST_FADE,
      ST_EMIT, ST_DONE
   } state_type;

   // Result handed from the controller to the output register.
   typedef struct packed {
      logic        status;
      logic        entry_valid;
      logic [5:0]  slot;
      logic [7:0]  kind_out;
      logic [7:0]  fade;
      logic        evicted;
      logic [6:0]  removed_count;
      logic        last;
   } result_type;
endpackage
`default_nettype wire

// ----- src/timed_entry_table_with_eviction_unit.sv -----
// Top level of the timed entry table: control sequencer, fade divider, entry memory and output register.
// The table holds up to 64 timed entries in one synchronous memory, with the valid
// bits in flip-flops. A transaction is taken only when the block is idle and the
// last result of the previous one has left. An insert below the limit goes straight
// to the write; an insert at the limit reads all 64 slots to find the entry with
// least time left, and a removal by owner or by kind reads all 64 slots as well. A
// scan reads the slots twice, once to drop expired entries and once to report the
// rest; a reported entry whose fade needs the divider waits on it. Results leave
// through a single output register, so the consumer may stall, and each result it
// holds off holds back the table.
`default_nettype none
module timed_entry_table_with_eviction_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // req_tdata fields from bit 0: now_ms[31:0], kind[7:0], lifespan_ms[30:0],
   // owner[31:0], then zero fill to 104 bits.
   input  wire logic [103:0] req_tdata,
   // req_tuser fields from bit 0: operation[1:0].
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rsp_tdata fields from bit 0: slot[5:0], kind_out[7:0], fade[7:0], evicted,
   // removed_count[6:0], then zero fill to 32 bits.
   output logic [31:0]       rsp_tdata,
   // rsp_tuser fields from bit 0: status, entry_valid.
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [6:0]   csr_data
);
   import tet_pkg::*;

   state_type state_ff, state_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [6:0]          limit_ff;
   logic                scan_en_ff;
   logic [1:0]          op_ff, op_in;
   logic [31:0]         now_ff, now_in, owner_ff, owner_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;
   logic [30:0]         span_ff, span_in;
   logic [SLOT_W:0]     idx_ff, idx_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic                have_ff, have_in;
   logic signed [31:0]  bleft_ff, bleft_in;
   logic [6:0]          rem_ff, rem_in;
   logic                ev_ff, ev_in;
   logic                pass_ff, pass_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic                outv_ff;
   result_type          out_ff;
   result_type          res;
   logic                res_push;
   logic                mem_we;
   logic [SLOT_W-1:0]   raddr;
   entry_type           rd;
   entry_type           wd;
   logic [SLOT_W-1:0]   free_slot;
   logic                free_any;
   logic [6:0]          eff_limit;
   logic [31:0]         age, left;
   logic [32:0]         t3;
   logic [29:0]         quarter;
   logic [32:0]         past_t3;
   logic                div_start, div_busy;
   logic [7:0]          quot;
   logic [7:0]          fade_ff, fade_in;
   logic [SLOT_W-1:0]   prev;

   tet_mem u_mem (.clock(clock), .we(mem_we), .waddr(free_slot), .wdata(wd),
      .raddr(raddr), .rdata(rd));

   tet_div u_div (.clock(clock), .reset(reset), .start(div_start),
      .rem_num(quarter - past_t3[29:0]), .q_den(quarter), .busy(div_busy),
      .quot(quot));

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !outv_ff;
   assign eff_limit  = (limit_ff > 7'(CAPACITY)) ? 7'(CAPACITY) : limit_ff;
   assign prev       = idx_ff[SLOT_W-1:0] - SLOT_W'(1);
   assign age        = now_ff - rd.start;
   assign left       = {1'b0, rd.span} - age;
   assign t3         = ({2'b0, rd.span} + {1'b0, rd.span, 1'b0}) >> 2;
   assign quarter    = {1'b0, rd.span[30:2]};
   assign past_t3    = {1'b0, age} - t3;
   assign wd         = '{kind: kind_ff, owner: owner_ff, start: now_ff, span: span_ff};

   always_comb begin
      free_slot = '0; free_any = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i); free_any = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; live_in = live_ff;
      op_in = op_ff; now_in = now_ff; owner_in = owner_ff; kind_in = kind_ff;
      span_in = span_ff; idx_in = idx_ff; best_in = best_ff; have_in = have_ff;
      bleft_in = bleft_ff; rem_in = rem_ff; ev_in = ev_ff; pass_in = pass_ff;
      cur_in = cur_ff; fade_in = fade_ff;
      res = '0; res_push = 1'b0; mem_we = 1'b0; div_start = 1'b0;
      raddr = idx_ff[SLOT_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in    = req_tuser;
               now_in   = req_tdata[31:0];
               kind_in  = req_tdata[32 +: KIND_BITS];
               span_in  = req_tdata[70:40];
               owner_in = req_tdata[102:71];
               idx_in = '0; rem_in = '0; ev_in = 1'b0; have_in = 1'b0;
               pass_in = 1'b0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            // Decide the item; the walk below issues slot reads one per cycle, pausing while a scan reports an entry.
            if (op_ff == OP_INSERT && eff_limit == 7'd0) begin
               res.status = 1'b1; res.last = 1'b1; res_push = 1'b1;
               state_in = ST_DONE;
            end else if (op_ff == OP_SCAN && !scan_en_ff) begin
               res.status = 1'b1; res.last = 1'b1; res_push = 1'b1;
               state_in = ST_DONE;
            end else if (op_ff == OP_INSERT && {1'b0, live_ff} < {1'b0, eff_limit}) begin
               state_in = ST_WRITE;
            end else begin
               raddr = '0; idx_in = 7'd1; state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            // rd holds the entry of slot prev.
            if (valid_ff[prev]) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (!have_ff || $signed(left) < bleft_ff) begin
                        have_in = 1'b1; best_in = prev; bleft_in = $signed(left);
                     end
                  end
                  OP_SCAN: begin
                     if (!pass_ff && age > {1'b0, rd.span}) begin
                        valid_in[prev] = 1'b0; live_in = live_ff - CNT_W'(1);
                        rem_in = rem_ff + 7'd1;
                     end
                  end
                  OP_REMOVE_OWNER: begin
                     if (rd.owner == owner_ff) begin
                        valid_in[prev] = 1'b0; live_in = live_ff - CNT_W'(1);
                        rem_in = rem_ff + 7'd1;
                     end
                  end
                  default: begin
                     if (rd.kind == kind_ff) begin
                        valid_in[prev] = 1'b0; live_in = live_ff - CNT_W'(1);
                        rem_in = rem_ff + 7'd1;
                     end
                  end
               endcase
            end
            if (op_ff == OP_SCAN && pass_ff && valid_ff[prev]) begin
               // Keep the reported slot on the read port until it is emitted.
               raddr = prev;
               cur_in = prev; state_in = ST_FADE;
               if ({1'b0, age} <= t3) begin
                  fade_in = 8'd255;
               end else if (quarter == '0 || past_t3 >= {3'b0, quarter}) begin
                  fade_in = 8'd0;
               end else begin
                  div_start = 1'b1; state_in = ST_SCAN;
               end
            end else if (idx_ff == 7'(CAPACITY)) begin
               state_in = ST_EVICT;
            end else begin
               idx_in = idx_ff + 7'd1;
            end
         end
         ST_SCAN: begin
            // Wait for the divider, then report.
            raddr = cur_ff;
            if (!div_busy) begin
               fade_in = quot; state_in = ST_FADE;
            end
         end
         ST_FADE: begin
            // Hold one reported entry back until the output register is free.
            raddr = cur_ff;
            if (!outv_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            res.entry_valid = 1'b1; res.slot = cur_ff;
            res.kind_out = 8'(rd.kind); res.fade = fade_ff;
            res_push = 1'b1; have_in = 1'b1;
            if (cur_ff == SLOT_W'(CAPACITY - 1) ||
                  ((valid_ff >> cur_ff) >> 1) == '0) begin
               res.removed_count = rem_ff; res.last = 1'b1;
               state_in = ST_DONE;
            end else begin
               raddr = cur_ff + SLOT_W'(1);
               idx_in = {1'b0, cur_ff} + 7'd2;
               state_in = ST_SEL;
            end
         end
         ST_EVICT: begin
            if (op_ff == OP_INSERT) begin
               if (have_ff) begin
                  valid_in[best_ff] = 1'b0; live_in = live_ff - CNT_W'(1);
                  ev_in = 1'b1;
               end
               state_in = ST_WRITE;
            end else if (op_ff == OP_SCAN && !pass_ff) begin
               pass_in = 1'b1; have_in = 1'b0; raddr = '0; idx_in = 7'd1;
               state_in = ST_SEL;
            end else begin
               // Removals, or a scan that found nothing to report.
               res.removed_count = rem_ff; res.last = 1'b1; res_push = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_WRITE: begin
            res.evicted = ev_ff; res.removed_count = {6'd0, ev_ff}; res.last = 1'b1;
            if (free_any) begin
               mem_we = 1'b1; valid_in[free_slot] = 1'b1;
               live_in = live_ff + CNT_W'(1);
               res.entry_valid = 1'b1; res.slot = free_slot;
               res.kind_out = 8'(kind_ff); res.fade = 8'd255;
            end
            res_push = 1'b1; state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; live_ff <= '0;
         limit_ff <= 7'(CAPACITY); scan_en_ff <= 1'b1; outv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; live_ff <= live_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENTRY_LIMIT) limit_ff <= csr_data;
            else scan_en_ff <= csr_data[0];
         end
         if (res_push) outv_ff <= 1'b1;
         else if (rsp_tready) outv_ff <= 1'b0;
      end
      if (res_push) out_ff <= res;
      op_ff <= op_in; now_ff <= now_in; owner_ff <= owner_in; kind_ff <= kind_in;
      span_ff <= span_in; idx_ff <= idx_in; best_ff <= best_in; have_ff <= have_in;
      bleft_ff <= bleft_in; rem_ff <= rem_in; ev_ff <= ev_in; pass_ff <= pass_in;
      cur_ff <= cur_in; fade_ff <= fade_in;
   end

   assign rsp_tvalid = outv_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = {out_ff.entry_valid, out_ff.status};
   assign rsp_tdata  = {2'd0, out_ff.removed_count, out_ff.evicted, out_ff.fade,
                        out_ff.kind_out, out_ff.slot};
endmodule
`default_nettype wire

// ----- src/tet_div.sv -----
// Restoring divider that forms floor(255*r/q) for the fade, one quotient bit per cycle.
`default_nettype none
module tet_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [29:0] rem_num,
   input  wire logic [29:0] q_den,
   output logic             busy,
   output logic [7:0]       quot
);
   import tet_pkg::*;
   // The quotient is below 256 since rem_num < q_den, so eight steps suffice
   // once the numerator is scaled by 255, as 255*rem_num stays below 256*q_den.
   logic [38:0] acc_ff, acc_in;
   logic [7:0]  q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [38:0] trial;
   always_comb begin
      acc_in = acc_ff; q_in = q_ff; cnt_in = cnt_ff;
      trial  = acc_ff - ({9'd0, q_den} << cnt_ff[2:0]);
      if (start) begin
         acc_in = ({9'd0, rem_num} << 8) - {9'd0, rem_num};
         q_in = '0; cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         trial = acc_ff - ({9'd0, q_den} << (cnt_ff - 4'd1));
         if (!trial[38]) begin
            acc_in = trial;
            q_in = q_ff | (8'd1 << (cnt_ff - 4'd1));
         end
         cnt_in = cnt_ff - 4'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0; else cnt_ff <= cnt_in;
      acc_ff <= acc_in; q_ff <= q_in;
   end
   assign busy = start || (cnt_ff != 4'd0);
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- src/tet_mem.sv -----
// Entry memory with one write port and one registered read port.
`default_nettype none
module tet_mem (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [tet_pkg::SLOT_W-1:0] waddr,
   input  wire tet_pkg::entry_type         wdata,
   input  wire logic [tet_pkg::SLOT_W-1:0] raddr,
   output tet_pkg::entry_type              rdata
);
   import tet_pkg::*;
   entry_type mem [CAPACITY];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- src/tet_checker.sv -----
// Port-level checker for the timed entry table and its bind statement.
`include "timed_entry_table_with_eviction_unit_macros.svh"
`default_nettype none
module tet_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [31:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         rsp_tlast
);
   `TET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TET_ASSERT_IMP(a_no_take_while_out, clock, reset, rsp_tvalid, !req_tready)
   `TET_ASSERT_IMP(a_ignored_is_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `TET_ASSERT_IMP(a_count_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[29:23] == 7'd0)
endmodule
bind timed_entry_table_with_eviction_unit tet_checker u_tet_checker (.*);
`default_nettype wire
